/* design/hssms_pkg.sv */
package hssms_pkg;

  // Command codes of the input item
  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_TURN   = 3'd1,
    CMD_ROTATE = 3'd2,
    CMD_MOVE   = 3'd3,
    CMD_STOP   = 3'd4
  } cmd_e;

  // Configuration register indexes
  localparam logic CFG_FORWARD       = 1'b0;
  localparam logic CFG_STEPS_PER_REV = 1'b1;

  // Register reset values
  localparam logic        FORWARD_RESET       = 1'b1;
  localparam logic [15:0] STEPS_PER_REV_RESET = 16'd4096;

  // Speed range and tick delay scaling
  localparam logic [6:0] SPEED_MAX   = 7'd100;
  localparam logic [9:0] DELAY_EXTRA = 10'd1;

  // Division by 360 as a shift by 3 and a division by 45 through a reciprocal
  localparam int          DIV_PRE_SHIFT = 3;
  localparam int          RECIP_SHIFT   = 35;
  localparam logic [29:0] RECIP_DIV45   = 30'd763549741;
  localparam logic [29:0] DIVISOR_45    = 30'd45;

  // Half-step coil pattern for a phase index
  function automatic logic [3:0] half_step_coils(input logic [2:0] idx);
    logic [3:0] pat;
    case (idx)
      3'd0: pat = 4'h8;
      3'd1: pat = 4'hC;
      3'd2: pat = 4'h4;
      3'd3: pat = 4'h6;
      3'd4: pat = 4'h2;
      3'd5: pat = 4'h3;
      3'd6: pat = 4'h1;
      3'd7: pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

/* design/half_step_stepper_motion_sequencer.sv */
// Half-step stepper motion sequencer.
// Input channel (in_valid_i / in_ready_o) carries one command item per
// transfer: a 1 ms tick, turn, rotate, move or stop, with amount and speed.
// Every item yields exactly one result item on the output channel
// (out_valid_o / out_ready_i): coil levels, enable, busy and phase index,
// showing the motion state after that item.
// Configuration (cfg_valid_i / cfg_ready_o) writes the direction (index 0)
// and half-steps per revolution (index 1); cfg_ready_o is always high, and
// writes are meant to happen only while no item is in flight.
// An accepted item is loaded into stage 1 with steps_per_rev * amount,
// then into stage 2 with its reciprocal estimate by 45; the last stage
// corrects the quotient, updates the motion state and loads the result
// register.
// Throughput is one item per cycle while the receiver takes results.
// When the receiver stalls, results hold and the stages behind fill up;
// input is still taken while any stage has room.
// Reset clears the pipeline, idles the motor with coils off and phase 0,
// and restores forward direction and 4096 half-steps per revolution.
module half_step_stepper_motion_sequencer
  import hssms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [15:0] amount_i,
  input  logic [6:0]  speed_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  coils_o,
  output logic        enabled_o,
  output logic        busy_res_o,
  output logic [2:0]  phase_o
);

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_COUNT = 2'd1,
    MODE_TIMED = 2'd2
  } mode_e;

  // Configuration registers
  logic        forward_q;
  logic [15:0] steps_per_rev_q;

  // Pipeline stages
  logic        s1_v_q, s2_v_q, out_v_q;
  logic [2:0]  s1_cmd_q, s2_cmd_q;
  logic [15:0] s1_amount_q, s2_amount_q;
  logic [6:0]  s1_speed_q, s2_speed_q;
  logic [31:0] s1_prod_q;
  logic [28:0] s2_x_q;
  logic [23:0] s2_q0_q;

  // Motion state
  mode_e       mode_q, mode_d;
  logic [2:0]  phase_q, phase_d;
  logic [3:0]  coils_q, coils_d;
  logic [23:0] remaining_q, remaining_d;
  logic [9:0]  wait_q, wait_d;
  logic [9:0]  reload_q, reload_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] limit_q, limit_d;

  // Handshake between stages
  logic out_free, s2_free, s1_free, s2_fire;

  assign out_free   = !out_v_q || out_ready_i;
  assign s2_free    = !s2_v_q || out_free;
  assign s1_free    = !s1_v_q || s2_free;
  assign s2_fire    = s2_v_q && out_free;
  assign in_ready_o = s1_free;

  // Write configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      forward_q       <= FORWARD_RESET;
      steps_per_rev_q <= STEPS_PER_REV_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FORWARD:       forward_q       <= cfg_data_i[0];
        CFG_STEPS_PER_REV: steps_per_rev_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: capture the item and form the rotate product
  logic [31:0] rot_prod;
  assign rot_prod = {16'd0, steps_per_rev_q} * {16'd0, amount_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_free) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_free) begin
      s1_cmd_q    <= command_i;
      s1_amount_q <= amount_i;
      s1_speed_q  <= speed_i;
      s1_prod_q   <= rot_prod;
    end
  end

  // Stage 2: estimate the quotient by 45 through the reciprocal
  logic [28:0] div_x;
  logic [58:0] recip_prod;
  assign div_x      = s1_prod_q[31:DIV_PRE_SHIFT];
  assign recip_prod = {30'd0, div_x} * {29'd0, RECIP_DIV45};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_free) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q && s2_free) begin
      s2_cmd_q    <= s1_cmd_q;
      s2_amount_q <= s1_amount_q;
      s2_speed_q  <= s1_speed_q;
      s2_x_q      <= div_x;
      s2_q0_q     <= recip_prod[58:RECIP_SHIFT];
    end
  end

  // Stage 3: correct the quotient (estimate is exact or one low)
  logic [29:0] q0_wide, q0_times45, div_rem;
  logic [23:0] rot_steps;
  assign q0_wide    = {6'd0, s2_q0_q};
  assign q0_times45 = (q0_wide << 5) + (q0_wide << 3) + (q0_wide << 2) + q0_wide;
  assign div_rem    = {1'b0, s2_x_q} - q0_times45;
  assign rot_steps  = (div_rem >= DIVISOR_45) ? s2_q0_q + 24'd1 : s2_q0_q;

  // Step delay from speed, saturated at the top speed
  logic [6:0] speed_sat, speed_gap;
  logic [9:0] step_delay;
  assign speed_sat  = (s2_speed_q > SPEED_MAX) ? SPEED_MAX : s2_speed_q;
  assign speed_gap  = SPEED_MAX - speed_sat;
  assign step_delay = ({3'd0, speed_gap} << 3) + ({3'd0, speed_gap} << 1) + DELAY_EXTRA;

  // Next phase and its coil pattern in the configured direction
  logic [2:0] step_phase;
  logic [3:0] step_coils;
  assign step_phase = forward_q ? phase_q + 3'd1 : phase_q - 3'd1;
  assign step_coils = half_step_coils(step_phase);

  // Tick helpers
  logic [15:0] elapsed_inc;
  logic [9:0]  wait_dec;
  assign elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
  assign wait_dec    = (wait_q != 10'd0) ? wait_q - 10'd1 : wait_q;

  logic        can_start;
  logic [23:0] count_steps;
  assign can_start   = (mode_q == MODE_IDLE) && (s2_speed_q != 7'd0);
  assign count_steps = (s2_cmd_q == CMD_ROTATE) ? rot_steps : {8'd0, s2_amount_q};

  // Update the motion state for the item leaving stage 2
  always_comb begin
    mode_d      = mode_q;
    phase_d     = phase_q;
    coils_d     = coils_q;
    remaining_d = remaining_q;
    wait_d      = wait_q;
    reload_d    = reload_q;
    elapsed_d   = elapsed_q;
    limit_d     = limit_q;
    if (s2_fire) begin
      case (s2_cmd_q)
        CMD_TICK: begin
          if (mode_q != MODE_IDLE) begin
            elapsed_d = elapsed_inc;
            wait_d    = wait_dec;
            if (wait_dec == 10'd0) begin
              if (mode_q == MODE_COUNT) begin
                if (remaining_q == 24'd0) begin
                  mode_d  = MODE_IDLE;
                  coils_d = 4'd0;
                end else begin
                  phase_d     = step_phase;
                  coils_d     = step_coils;
                  remaining_d = remaining_q - 24'd1;
                  wait_d      = reload_q;
                end
              end else begin
                if (elapsed_inc < limit_q) begin
                  phase_d = step_phase;
                  coils_d = step_coils;
                  wait_d  = reload_q;
                end else begin
                  mode_d  = MODE_IDLE;
                  coils_d = 4'd0;
                end
              end
            end
          end
        end
        CMD_TURN, CMD_ROTATE: begin
          if (can_start) begin
            if (count_steps == 24'd0) begin
              mode_d  = MODE_IDLE;
              coils_d = 4'd0;
            end else begin
              reload_d    = step_delay;
              phase_d     = step_phase;
              coils_d     = step_coils;
              remaining_d = count_steps - 24'd1;
              wait_d      = step_delay;
              mode_d      = MODE_COUNT;
            end
          end
        end
        CMD_MOVE: begin
          if (can_start) begin
            if (s2_amount_q == 16'd0) begin
              mode_d  = MODE_IDLE;
              coils_d = 4'd0;
            end else begin
              reload_d  = step_delay;
              limit_d   = s2_amount_q;
              elapsed_d = 16'd0;
              phase_d   = step_phase;
              coils_d   = step_coils;
              wait_d    = step_delay;
              mode_d    = MODE_TIMED;
            end
          end
        end
        CMD_STOP: begin
          mode_d  = MODE_IDLE;
          coils_d = 4'd0;
        end
        default: ;
      endcase
    end
  end

  // Hold motion state and result valid; state doubles as result payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q     <= 1'b0;
      mode_q      <= MODE_IDLE;
      phase_q     <= 3'd0;
      coils_q     <= 4'd0;
      remaining_q <= 24'd0;
      wait_q      <= 10'd0;
      reload_q    <= 10'd0;
      elapsed_q   <= 16'd0;
      limit_q     <= 16'd0;
    end else begin
      if (out_free) begin
        out_v_q <= s2_v_q;
      end
      mode_q      <= mode_d;
      phase_q     <= phase_d;
      coils_q     <= coils_d;
      remaining_q <= remaining_d;
      wait_q      <= wait_d;
      reload_q    <= reload_d;
      elapsed_q   <= elapsed_d;
      limit_q     <= limit_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign coils_o     = coils_q;
  assign enabled_o   = (mode_q != MODE_IDLE);
  assign busy_res_o  = (mode_q != MODE_IDLE);
  assign phase_o     = phase_q;

  // Coils are off whenever no motion runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_IDLE) |-> (coils_q == 4'd0))
    else $error("coils driven while idle");

  // A running motion always has a pending wait and a nonzero reload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_IDLE) |-> (wait_q != 10'd0) && (reload_q != 10'd0))
    else $error("running motion without pending wait");

  // A timed move always carries a nonzero time limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_TIMED) |-> (limit_q != 16'd0))
    else $error("timed move without a time limit");

  // Phase only moves when an item is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s2_fire |=> $stable(phase_q))
    else $error("phase moved without an item");

endmodule
